// ===== src/tile_row_burst_address_generator_assert.svh =====
// Assertion macros shared by the tile row burst address generator.
`ifndef TILE_ROW_BURST_ADDRESS_GENERATOR_ASSERT_SVH
`define TILE_ROW_BURST_ADDRESS_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define TRBAG_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tile row burst address generator: assertion failed");

// Next-cycle implication, disabled while reset is held.
`define TRBAG_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tile row burst address generator: assertion failed");

`endif

// ===== src/trbag_pkg.sv =====
package trbag_pkg;

    // Channel and field widths.
    localparam int CH_W        = 16;
    localparam int ROWB_W      = 12;
    localparam int COLB_W      = 12;
    localparam int ADDR_W      = 32;
    localparam int BUF_W       = 16;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PLANE_HEIGHT  = 3'd0,
        REG_PLANE_WIDTH   = 3'd1,
        REG_TILE_CHANNELS = 3'd2,
        REG_TILE_ROWS     = 3'd3,
        REG_TILE_COLS     = 3'd4,
        REG_ROW_HALO      = 3'd5,
        REG_COL_HALO      = 3'd6,
        REG_BASE_OFFSET   = 3'd7
    } trbag_reg_t;

    // Current register contents.
    typedef struct packed {
        logic        [12:0] plane_height;
        logic        [12:0] plane_width;
        logic        [10:0] tile_channels;
        logic        [8:0]  tile_rows;
        logic        [8:0]  tile_cols;
        logic signed [8:0]  row_halo;
        logic signed [8:0]  col_halo;
        logic        [31:0] base_offset;
    } trbag_cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic mul1;
        logic mul2;
        logic sum;
        logic div_start;
        logic prep;
        logic emit;
    } trbag_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic div_done;
        logic out_free;
        logic last_row;
    } trbag_sts_t;

endpackage

// ===== src/trbag_cfg.sv =====
module trbag_cfg
    import trbag_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output trbag_cfg_t            cfg
);

    trbag_cfg_t cfg_reg;

    // Writes are taken in any cycle.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register file with its reset values.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.plane_height  <= 13'd1;
            cfg_reg.plane_width   <= 13'd1;
            cfg_reg.tile_channels <= 11'd1;
            cfg_reg.tile_rows     <= 9'd1;
            cfg_reg.tile_cols     <= 9'd1;
            cfg_reg.row_halo      <= '0;
            cfg_reg.col_halo      <= '0;
            cfg_reg.base_offset   <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (trbag_reg_t'(cfg_index))
                REG_PLANE_HEIGHT:  cfg_reg.plane_height  <= cfg_data[12:0];
                REG_PLANE_WIDTH:   cfg_reg.plane_width   <= cfg_data[12:0];
                REG_TILE_CHANNELS: cfg_reg.tile_channels <= cfg_data[10:0];
                REG_TILE_ROWS:     cfg_reg.tile_rows     <= cfg_data[8:0];
                REG_TILE_COLS:     cfg_reg.tile_cols     <= cfg_data[8:0];
                REG_ROW_HALO:      cfg_reg.row_halo      <= $signed(cfg_data[8:0]);
                REG_COL_HALO:      cfg_reg.col_halo      <= $signed(cfg_data[8:0]);
                REG_BASE_OFFSET:   cfg_reg.base_offset   <= cfg_data;
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

endmodule

// ===== src/trbag_div.sv =====
module trbag_div #(
    parameter int DIVISOR = 16,
    parameter int WIDTH   = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic [WIDTH-1:0]                      dividend,
    output logic                                  done,
    output logic [WIDTH-1:0]                      quotient,
    output logic [$clog2(DIVISOR+1)-1:0]          remainder
);

    // Radix-16 restoring division: four quotient bits per cycle.
    localparam int DIGIT = 4;
    localparam int STEPS = (WIDTH + DIGIT - 1) / DIGIT;
    localparam int PADW  = STEPS * DIGIT;
    localparam int RB    = $clog2(DIVISOR + 1);
    localparam int CW    = $clog2(STEPS + 1);
    localparam logic [RB:0] DIV_C = (RB+1)'(DIVISOR);

    logic [PADW-1:0] num_reg, num_next, num_work;
    logic [RB-1:0]   rem_reg, rem_next, rem_work;
    logic [RB:0]     trial;
    logic [CW-1:0]   cnt_reg;
    logic            done_reg;

    // One digit: shift in the next dividend bit and subtract where it fits.
    always_comb begin
        num_work = num_reg;
        rem_work = rem_reg;
        trial    = '0;
        for (int i = 0; i < DIGIT; i++) begin
            trial    = {rem_work, num_work[PADW-1]};
            num_work = {num_work[PADW-2:0], 1'b0};
            if (trial >= DIV_C) begin
                trial       = trial - DIV_C;
                num_work[0] = 1'b1;
            end
            rem_work = trial[RB-1:0];
        end
        num_next = num_work;
        rem_next = rem_work;
    end

    // Step counter and done pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (start) begin
            cnt_reg  <= CW'(STEPS);
            done_reg <= 1'b0;
        end else begin
            done_reg <= (cnt_reg == CW'(1));
            if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // The dividend register turns into the quotient as bits shift through.
    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= PADW'(dividend);
            rem_reg <= '0;
        end else if (cnt_reg != '0) begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = num_reg[WIDTH-1:0];
    assign remainder = rem_reg;

endmodule

// ===== src/trbag_dp.sv =====
module trbag_dp
    import trbag_pkg::*;
#(
    parameter int PACK_FACTOR   = 16,
    parameter int MAX_TILE_ROWS = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  trbag_cfg_t            cfg,
    input  trbag_cmd_t            cmd,
    output trbag_sts_t            sts,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tlast
);

    localparam int RB = $clog2(PACK_FACTOR + 1);
    localparam int RW = $clog2(MAX_TILE_ROWS + 1);
    localparam longint unsigned TWO32 = 64'h1_0000_0000;
    localparam longint unsigned Q32_L = TWO32 / PACK_FACTOR;
    localparam longint unsigned R32_L = TWO32 % PACK_FACTOR;
    localparam logic [ADDR_W-1:0] Q32_C = Q32_L[ADDR_W-1:0];
    localparam logic [RB:0]       R32_C = (RB+1)'(R32_L);
    localparam logic [RB:0]       P_C   = (RB+1)'(PACK_FACTOR);
    localparam logic signed [10:0] MAX_ROWS_S = 11'(MAX_TILE_ROWS);
    localparam logic [31:0]        ROUND_C    = 32'(PACK_FACTOR - 1);

    // Captured request.
    logic [CH_W-1:0]   ch_reg;
    logic [ROWB_W-1:0] rb_reg;
    logic [COLB_W-1:0] cb_reg;

    // Setup products and sums.
    logic [25:0]       area_reg;
    logic [22:0]       cbt_reg;
    logic [23:0]       stride_reg;
    logic [20:0]       elems_reg, elems_next;
    logic [RW-1:0]     nrows_reg;
    logic [41:0]       chp_full;
    logic [35:0]       rbs_full;
    logic [ADDR_W-1:0] chp_reg, rbs_reg, part_reg, addr0_reg;

    // Row geometry from the registers.
    logic signed [10:0] rows_s, cols_s;
    logic               cols_pos;
    logic [RW-1:0]      nrows_next;

    // Divider results.
    logic              div_done, div_s_done, div_e_done;
    logic [ADDR_W-1:0] a_quo, s_quo, e_quo;
    logic [RB-1:0]     a_rem, s_rem, e_rem;

    // Row walk state: address as quotient and remainder plus the raw word.
    logic [ADDR_W-1:0] q_reg, q_next, sq_reg, sqw_reg, q_adj;
    logic [RB-1:0]     r_reg, r_next, sr_reg, t1;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W:0]   addr_sum;
    logic [BUF_W-1:0]  buf_reg, words_reg;
    logic [RW-1:0]     row_cnt_reg;
    logic [RB:0]       t_sum, t_red, wrap_sub, t2, t_fix;
    logic              wrap, carry_r, borrow_r;

    // Output register.
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tlast_reg;

    // Row and column counts with halo.
    always_comb begin
        rows_s   = $signed({2'b00, cfg.tile_rows}) + 11'(cfg.row_halo);
        cols_s   = $signed({2'b00, cfg.tile_cols}) + 11'(cfg.col_halo);
        cols_pos = (cols_s > 11'sd0);
        if (rows_s > MAX_ROWS_S) begin
            nrows_next = RW'(MAX_TILE_ROWS);
        end else begin
            nrows_next = rows_s[RW-1:0];
        end
        elems_next = cols_pos ? cols_s[9:0] * cfg.tile_channels : '0;
        chp_full   = ch_reg * area_reg;
        rbs_full   = rb_reg * stride_reg;
    end

    // Setup stages.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            ch_reg <= s_tdata[15:0];
            rb_reg <= s_tdata[27:16];
            cb_reg <= s_tdata[39:28];
        end
        if (cmd.mul1) begin
            area_reg   <= cfg.plane_height * cfg.plane_width;
            cbt_reg    <= cb_reg * cfg.tile_channels;
            stride_reg <= cfg.plane_width * cfg.tile_channels;
            elems_reg  <= elems_next;
            nrows_reg  <= nrows_next;
        end
        if (cmd.mul2) begin
            chp_reg  <= chp_full[ADDR_W-1:0];
            rbs_reg  <= rbs_full[ADDR_W-1:0];
            part_reg <= {9'b0, cbt_reg} + cfg.base_offset;
        end
        if (cmd.sum) begin
            addr0_reg <= chp_reg + rbs_reg + part_reg;
        end
    end

    // Division by the pack factor of start address, stride and rounded length.
    trbag_div #(.DIVISOR(PACK_FACTOR), .WIDTH(ADDR_W)) u_div_addr (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (addr0_reg),
        .done      (div_done),
        .quotient  (a_quo),
        .remainder (a_rem)
    );

    trbag_div #(.DIVISOR(PACK_FACTOR), .WIDTH(ADDR_W)) u_div_stride (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  ({8'b0, stride_reg}),
        .done      (div_s_done),
        .quotient  (s_quo),
        .remainder (s_rem)
    );

    trbag_div #(.DIVISOR(PACK_FACTOR), .WIDTH(ADDR_W)) u_div_len (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  ({11'b0, elems_reg} + ROUND_C),
        .done      (div_e_done),
        .quotient  (e_quo),
        .remainder (e_rem)
    );

    // Next row: add the stride in quotient and remainder form, then fold
    // back 2^32 when the raw address wraps.
    always_comb begin
        addr_sum = {1'b0, addr_reg} + {9'b0, stride_reg};
        wrap     = addr_sum[ADDR_W];
        t_sum    = {1'b0, r_reg} + {1'b0, sr_reg};
        carry_r  = (t_sum >= P_C);
        t_red    = carry_r ? (t_sum - P_C) : t_sum;
        t1       = t_red[RB-1:0];
        wrap_sub = wrap ? R32_C : '0;
        borrow_r = ({1'b0, t1} < wrap_sub);
        t2       = {1'b0, t1} - wrap_sub;
        t_fix    = t2 + P_C;
        r_next   = borrow_r ? t_fix[RB-1:0] : t2[RB-1:0];
        if (carry_r && !borrow_r) begin
            q_adj = 32'd1;
        end else if (!carry_r && borrow_r) begin
            q_adj = '1;
        end else begin
            q_adj = '0;
        end
        q_next = q_reg + (wrap ? sqw_reg : sq_reg) + q_adj;
    end

    // Row walk registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_cnt_reg <= '0;
        end else if (cmd.prep) begin
            row_cnt_reg <= '0;
        end else if (cmd.emit) begin
            row_cnt_reg <= sts.last_row ? '0 : row_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            q_reg     <= a_quo;
            r_reg     <= a_rem;
            addr_reg  <= addr0_reg;
            sq_reg    <= s_quo;
            sqw_reg   <= s_quo - Q32_C;
            sr_reg    <= s_rem;
            buf_reg   <= '0;
            words_reg <= (e_quo[ADDR_W-1:BUF_W] != '0) ? '1 : e_quo[BUF_W-1:0];
        end else if (cmd.emit) begin
            q_reg    <= q_next;
            r_reg    <= r_next;
            addr_reg <= addr_sum[ADDR_W-1:0];
            buf_reg  <= buf_reg + words_reg;
        end
    end

    // Output register: a descriptor waits here while the next one is built.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= {words_reg, buf_reg, q_reg};
            m_tlast_reg <= sts.last_row;
        end
    end

    // Status to the controller.
    assign sts.empty    = (rows_s <= 11'sd0);
    assign sts.div_done = div_done;
    assign sts.out_free = !m_tvalid_reg || m_tready;
    assign sts.last_row = (row_cnt_reg == nrows_reg - 1'b1);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ===== src/trbag_ctrl.sv =====
module trbag_ctrl
    import trbag_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  trbag_sts_t sts,
    output trbag_cmd_t cmd
);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_MUL1 = 8'b0000_0010,
        ST_MUL2 = 8'b0000_0100,
        ST_SUM  = 8'b0000_1000,
        ST_DIVS = 8'b0001_0000,
        ST_DIVW = 8'b0010_0000,
        ST_PREP = 8'b0100_0000,
        ST_EMIT = 8'b1000_0000
    } trbag_state_t;

    trbag_state_t state_reg, state_next;

    // Sequence: multiplies (back to idle if no rows), address sum, division, prep, then one row a transfer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1: state_next = sts.empty ? ST_IDLE : ST_MUL2;
            ST_MUL2: state_next = ST_SUM;
            ST_SUM:  state_next = ST_DIVS;
            ST_DIVS: state_next = ST_DIVW;
            ST_DIVW: begin
                if (sts.div_done) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: state_next = ST_EMIT;
            ST_EMIT: begin
                if (sts.out_free && sts.last_row) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Commands follow the state.
    assign s_tready      = (state_reg == ST_IDLE);
    assign cmd.capture   = (state_reg == ST_IDLE) && s_tvalid;
    assign cmd.mul1      = (state_reg == ST_MUL1);
    assign cmd.mul2      = (state_reg == ST_MUL2);
    assign cmd.sum       = (state_reg == ST_SUM);
    assign cmd.div_start = (state_reg == ST_DIVS);
    assign cmd.prep      = (state_reg == ST_PREP);
    assign cmd.emit      = (state_reg == ST_EMIT) && sts.out_free;

endmodule

// ===== src/tile_row_burst_address_generator.sv =====
// Tile row burst address generator: each tile request on the s_ side yields one burst
// descriptor per tile row on the m_ side, with m_tlast on the final row. The row count is
// tile_rows + row_halo clamped to MAX_TILE_ROWS; a request with no rows yields nothing and
// frees the input again after the first multiply state. Otherwise a request passes through
// multiplies and sums, division by PACK_FACTOR in a radix-16 divider that resolves four
// bits of a 32-bit word per cycle, preparation, and then one descriptor per cycle while
// the output is not stalled, each row address stepped by one add. Configuration must be
// written while no request is in flight.
`include "tile_row_burst_address_generator_assert.svh"

module tile_row_burst_address_generator
    import trbag_pkg::*;
#(
    parameter int PACK_FACTOR   = 16,
    parameter int MAX_TILE_ROWS = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // channel_base [15:0], row_base [27:16], col_base [39:28]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // dram_word_addr [31:0], buffer_word_addr [47:32], burst_words [63:48]
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tlast
);

    trbag_cfg_t cfg;
    trbag_cmd_t cmd;
    trbag_sts_t sts;

    trbag_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    trbag_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    trbag_dp #(
        .PACK_FACTOR   (PACK_FACTOR),
        .MAX_TILE_ROWS (MAX_TILE_ROWS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // A request is worked on alone: the input closes right after a transfer.
    `TRBAG_ASSERT_NXT(a_accept_closes_input, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // While rows of a tile remain, the input stays closed.
    `TRBAG_ASSERT_IMP(a_mid_tile_busy, aclk, aresetn, m_tvalid && m_tready && !m_tlast, !s_tready)

    // Rows of one tile follow each other without a gap.
    `TRBAG_ASSERT_NXT(a_rows_back_to_back, aclk, aresetn, m_tvalid && m_tready && !m_tlast, m_tvalid)

endmodule
